FILE: rtl/core/sll_pkg.sv
// shared types, character codes, token codes and keyword table for the stack language lexer
// used by sll_ctrl, sll_dpath and stack_language_lexer; no dependencies
package sll_pkg;

	// longest token text held in the text store
	localparam int MAX_TOKEN_CHARS = 32;
	localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);
	localparam int IDX_W = $clog2(MAX_TOKEN_CHARS);

	// input and result beats
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_end;
	} lex_in_t;

	typedef struct packed {
		logic        has_token;
		logic [4:0]  token_type;
		logic [7:0]  text_char;
		logic [31:0] number_value;
		logic [2:0]  error_code;
		logic        last;
	} lex_out_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_STR_CHAR = 3'd1,
		ERR_FLOAT    = 3'd2,
		ERR_UNKNOWN  = 3'd3,
		ERR_TOO_LONG = 3'd4,
		ERR_UNTERM   = 3'd5
	} err_code_t;

	typedef enum logic [1:0] {
		FK_WORD   = 2'd0,
		FK_NUMBER = 2'd1,
		FK_STRING = 2'd2
	} flush_kind_t;

	// token type codes
	localparam logic [4:0] TT_NONE   = 5'd0;
	localparam logic [4:0] TT_NUMBER = 5'd3;
	localparam logic [4:0] TT_STRING = 5'd5;
	localparam logic [4:0] TT_WORD   = 5'd30;

	// character codes
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_BSLASH  = 8'h5c;

	// controller to datapath commands
	typedef struct packed {
		logic        clear;
		logic        append;
		logic        add_digit;
		logic        kw_track;
		logic [7:0]  ch;
		logic        flush;
		flush_kind_t kind;
		logic        emit_beat;
		logic        single;
		logic        s_has;
		logic [4:0]  s_type;
		err_code_t   s_err;
	} sll_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic len_full;
		logic len_zero;
		logic emit_last;
		logic out_free;
	} sll_sts_t;

	// alphanumeric keywords only; text right-justified, codes as in the language
	localparam int KW_N = 18;
	localparam int KW_IDX_W = $clog2(KW_N);

	localparam logic [55:0] KW_TEXT [KW_N] = '{
		56'("EOF"), 56'("NEWLINE"), 56'("NUMBER"), 56'("VAR"), 56'("STRING"),
		56'("DUP"), 56'("POP"), 56'("SWP"), 56'("OVR"), 56'("ROT"),
		56'("AND"), 56'("ORR"), 56'("INV"), 56'("DGT"), 56'("LTR"),
		56'("STK"), 56'("RTN"), 56'("BYE")
	};

	localparam logic [2:0] KW_LEN [KW_N] = '{
		3'd3, 3'd7, 3'd6, 3'd3, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
	};

	localparam logic [4:0] KW_CODE [KW_N] = '{
		5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
		5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd28
	};

	// character p of keyword k, p below the keyword length
	function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] k, input logic [2:0] p);
		logic [55:0] t;
		t = KW_TEXT[k] >> {3'(KW_LEN[k] - 3'd1 - p), 3'b000};
		return t[7:0];
	endfunction

	// single-character operators, TT_NONE when not an operator
	function automatic logic [4:0] op_type(input logic [7:0] c);
		logic [4:0] t;
		unique case (c)
			8'h2b:   t = 5'd11; // plus
			8'h2d:   t = 5'd12; // minus
			8'h2a:   t = 5'd13; // star
			8'h2f:   t = 5'd14; // slash
			8'h25:   t = 5'd15; // percent
			8'h3d:   t = 5'd16; // equals
			8'h21:   t = 5'd17; // bang
			8'h3e:   t = 5'd18; // greater
			8'h3c:   t = 5'd19; // less
			8'h3a:   t = 5'd27; // colon
			default: t = TT_NONE;
		endcase
		return t;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
	endfunction

endpackage

FILE: rtl/core/sll_dpath.sv
// lexer datapath: text store, length, number accumulator, keyword match, result register
// depends on sll_pkg; driven by sll_ctrl commands
module sll_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  sll_pkg::sll_cmd_t cmd,
	output sll_pkg::sll_sts_t sts,
	output logic              tok_valid,
	input  logic              tok_ready,
	output sll_pkg::lex_out_t tok_beat
);
	import sll_pkg::*;

	logic [7:0]       text_mem [MAX_TOKEN_CHARS];
	logic [7:0]       rdata_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	logic [LEN_W-1:0] len_q, len_d, base_len, emit_cnt_q, emit_nxt;
	logic [31:0]      acc_q, acc_d, base_acc;
	logic [35:0]      acc_sum;
	logic [KW_N-1:0]  match_q, match_d;
	logic [4:0]       kw_type, emit_type_q;
	logic             emit_num_q;
	logic             out_valid_q, out_free, emit_last;
	lex_out_t         out_q;

	assign out_free  = !out_valid_q || tok_ready;
	assign emit_nxt  = emit_cnt_q + LEN_W'(1);
	assign emit_last = (emit_nxt == len_q);

	assign sts.len_full  = (len_q == LEN_W'(MAX_TOKEN_CHARS));
	assign sts.len_zero  = (len_q == '0);
	assign sts.emit_last = emit_last;
	assign sts.out_free  = out_free;

	// token bookkeeping, clear and first append may come together
	always_comb begin
		base_len = cmd.clear ? '0 : len_q;
		base_acc = cmd.clear ? '0 : acc_q;
		len_d    = base_len;
		if (cmd.append)
			len_d = base_len + LEN_W'(1);
		acc_sum = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1) + 36'(cmd.ch[3:0]);
		acc_d   = base_acc;
		if (cmd.add_digit)
			acc_d = (acc_sum > 36'hffff_ffff) ? 32'hffff_ffff : acc_sum[31:0];
		for (int k = 0; k < KW_N; k++) begin
			match_d[k] = cmd.clear ? 1'b1 : match_q[k];
			if (cmd.kw_track)
				match_d[k] = match_d[k] && (base_len < LEN_W'(KW_LEN[KW_IDX_W'(k)]))
					&& (kw_char(KW_IDX_W'(k), base_len[2:0]) == cmd.ch);
		end
	end

	// first keyword whose text matches over the full word length
	always_comb begin
		kw_type = TT_WORD;
		for (int k = KW_N - 1; k >= 0; k--)
			if (match_q[k] && len_q == LEN_W'(KW_LEN[KW_IDX_W'(k)]))
				kw_type = KW_CODE[KW_IDX_W'(k)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			acc_q   <= '0;
			match_q <= '0;
		end else begin
			len_q   <= len_d;
			acc_q   <= acc_d;
			if (cmd.clear || cmd.kw_track)
				match_q <= match_d;
		end
	end

	// text store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.append)
			text_mem[base_len[IDX_W-1:0]] <= cmd.ch;
	end

	assign rd_en   = cmd.flush || cmd.emit_beat;
	assign rd_addr = cmd.flush ? '0 : emit_nxt[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= text_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_cnt_q <= '0;
		end else if (cmd.flush) begin
			emit_cnt_q <= '0;
		end else if (cmd.emit_beat) begin
			emit_cnt_q <= emit_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			case (cmd.kind)
				FK_WORD:   emit_type_q <= kw_type;
				FK_NUMBER: emit_type_q <= TT_NUMBER;
				default:   emit_type_q <= TT_STRING;
			endcase
			emit_num_q <= (cmd.kind == FK_NUMBER);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.single || cmd.emit_beat) begin
			out_valid_q <= 1'b1;
		end else if (tok_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_beat) begin
			out_q.has_token    <= 1'b1;
			out_q.token_type   <= emit_type_q;
			out_q.text_char    <= rdata_q;
			out_q.number_value <= emit_num_q ? acc_q : 32'd0;
			out_q.error_code   <= ERR_NONE;
			out_q.last         <= emit_last;
		end else if (cmd.single) begin
			out_q.has_token    <= cmd.s_has;
			out_q.token_type   <= cmd.s_type;
			out_q.text_char    <= cmd.s_has ? cmd.ch : 8'd0;
			out_q.number_value <= 32'd0;
			out_q.error_code   <= cmd.s_err;
			out_q.last         <= 1'b1;
		end
	end

	assign tok_valid = out_valid_q;
	assign tok_beat  = out_q;

endmodule

FILE: rtl/core/sll_ctrl.sv
// lexer controller: lexing mode, beat sequencing, byte decode into datapath commands
// depends on sll_pkg; pairs with sll_dpath
module sll_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_ready,
	input  sll_pkg::lex_in_t  char_beat,
	input  sll_pkg::sll_sts_t sts,
	output sll_pkg::sll_cmd_t cmd
);
	import sll_pkg::*;

	typedef enum logic [2:0] {
		SQ_ACCEPT = 3'b001,
		SQ_EMIT   = 3'b010,
		SQ_REPLAY = 3'b100
	} seq_t;

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_STRING  = 5'b00010,
		MODE_WORD    = 5'b00100,
		MODE_NUMBER  = 5'b01000,
		MODE_STOPPED = 5'b10000
	} mode_t;

	seq_t       seq_q, seq_d;
	mode_t      mode_q, mode_d;
	logic       replay_q, replay_d;
	logic [7:0] byte_q, byte_d;
	logic       act, end_flag;
	logic [7:0] c;
	logic [4:0] op;

	assign char_ready = (seq_q == SQ_ACCEPT) && sts.out_free;

	always_comb begin
		cmd      = '0;
		seq_d    = seq_q;
		mode_d   = mode_q;
		replay_d = replay_q;
		byte_d   = byte_q;
		act      = 1'b0;
		end_flag = 1'b0;
		c        = char_beat.char_code;

		unique case (seq_q)
			SQ_ACCEPT: begin
				act      = char_valid && sts.out_free;
				end_flag = char_beat.is_end;
			end
			SQ_REPLAY: begin
				act = sts.out_free;
				c   = byte_q;
			end
			SQ_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_beat = 1'b1;
					if (sts.emit_last)
						seq_d = replay_q ? SQ_REPLAY : SQ_ACCEPT;
				end
			end
			default: seq_d = SQ_ACCEPT;
		endcase

		op     = op_type(c);
		cmd.ch = c;

		if (act) begin
			if (seq_q == SQ_REPLAY)
				seq_d = SQ_ACCEPT;
			if (end_flag) begin
				mode_d = MODE_IDLE;
				unique case (mode_q) inside
					MODE_STRING: begin
						cmd.single = 1'b1;
						cmd.s_err  = ERR_UNTERM;
					end
					MODE_WORD, MODE_NUMBER: begin
						cmd.flush = 1'b1;
						cmd.kind  = (mode_q == MODE_WORD) ? FK_WORD : FK_NUMBER;
						seq_d     = SQ_EMIT;
						replay_d  = 1'b0;
					end
					default: ;
				endcase
			end else begin
				unique case (mode_q)
					MODE_IDLE: begin
						if (c == CH_SPACE || c == CH_NL) begin
						end else if (op != TT_NONE) begin
							cmd.single = 1'b1;
							cmd.s_has  = 1'b1;
							cmd.s_type = op;
						end else if (c == CH_QUOTE) begin
							cmd.clear = 1'b1;
							mode_d    = MODE_STRING;
						end else if (is_alpha(c)) begin
							cmd.clear    = 1'b1;
							cmd.append   = 1'b1;
							cmd.kw_track = 1'b1;
							cmd.ch       = to_upper(c);
							mode_d       = MODE_WORD;
						end else if (is_digit(c)) begin
							cmd.clear     = 1'b1;
							cmd.append    = 1'b1;
							cmd.add_digit = 1'b1;
							mode_d        = MODE_NUMBER;
						end else begin
							cmd.single = 1'b1;
							cmd.s_err  = ERR_UNKNOWN;
						end
					end
					MODE_STRING: begin
						if (c == CH_QUOTE) begin
							mode_d = MODE_IDLE;
							if (sts.len_zero) begin
								// empty string: one beat without text
								cmd.single = 1'b1;
								cmd.s_type = TT_STRING;
							end else begin
								cmd.flush = 1'b1;
								cmd.kind  = FK_STRING;
								seq_d     = SQ_EMIT;
								replay_d  = 1'b0;
							end
						end else if (c == CH_NL || c == CH_TAB || c == CH_CR ||
								c == CH_BSLASH || c == CH_PERCENT) begin
							cmd.single = 1'b1;
							cmd.s_err  = ERR_STR_CHAR;
							cmd.clear  = 1'b1;
							mode_d     = MODE_STOPPED;
						end else if (sts.len_full) begin
							cmd.single = 1'b1;
							cmd.s_err  = ERR_TOO_LONG;
							cmd.clear  = 1'b1;
							mode_d     = MODE_STOPPED;
						end else begin
							cmd.append = 1'b1;
						end
					end
					MODE_WORD: begin
						if (is_alpha(c) || is_digit(c)) begin
							if (sts.len_full) begin
								cmd.single = 1'b1;
								cmd.s_err  = ERR_TOO_LONG;
								cmd.clear  = 1'b1;
								mode_d     = MODE_STOPPED;
							end else begin
								cmd.append   = 1'b1;
								cmd.kw_track = 1'b1;
								cmd.ch       = to_upper(c);
							end
						end else begin
							// word ends here, its terminator runs again in idle mode
							cmd.flush = 1'b1;
							cmd.kind  = FK_WORD;
							seq_d     = SQ_EMIT;
							replay_d  = 1'b1;
							byte_d    = c;
							mode_d    = MODE_IDLE;
						end
					end
					MODE_NUMBER: begin
						if (is_digit(c)) begin
							if (sts.len_full) begin
								cmd.single = 1'b1;
								cmd.s_err  = ERR_TOO_LONG;
								cmd.clear  = 1'b1;
								mode_d     = MODE_STOPPED;
							end else begin
								cmd.append    = 1'b1;
								cmd.add_digit = 1'b1;
							end
						end else if (c == CH_DOT) begin
							cmd.single = 1'b1;
							cmd.s_err  = ERR_FLOAT;
							cmd.clear  = 1'b1;
							mode_d     = MODE_STOPPED;
						end else begin
							cmd.flush = 1'b1;
							cmd.kind  = FK_NUMBER;
							seq_d     = SQ_EMIT;
							replay_d  = 1'b1;
							byte_d    = c;
							mode_d    = MODE_IDLE;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= SQ_ACCEPT;
			mode_q   <= MODE_IDLE;
			replay_q <= 1'b0;
		end else begin
			seq_q    <= seq_d;
			mode_q   <= mode_d;
			replay_q <= replay_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
	end

endmodule

FILE: rtl/core/stack_language_lexer.sv
// stack language lexer, top level: controller plus datapath
// depends on sll_pkg, sll_ctrl, sll_dpath
//
// usage
//   char channel (char_valid/char_ready/char_beat): one source byte per beat,
//   or an end beat with is_end set that flushes a pending word or number,
//   reports an open string and clears the stopped condition
//   tok channel (tok_valid/tok_ready/tok_beat): result beats; token text goes
//   out one character per beat with last on the final one, errors are single
//   beats with last set
// timing and throughput
//   a byte that makes at most one result is taken when the output is free; its result shows
//   in the output register the cycle after it is taken
//   a byte that finishes a word, number or string starts a flush that reads the
//   first character; the text goes out one character per beat, then the terminating
//   byte of a word or number runs again in idle mode; the text store has one read
//   port and the result register takes one character per cycle when free
// reset
//   arst_n clears the lexing mode to idle, the token length and accumulator,
//   and empties the output register; the text store is not cleared
// stalls
//   while a result is held with tok_ready low, char_ready stays low, as it
//   does while token text goes out or a terminator is run again; nothing is dropped
module stack_language_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_ready,
	input  sll_pkg::lex_in_t  char_beat,
	output logic              tok_valid,
	input  logic              tok_ready,
	output sll_pkg::lex_out_t tok_beat
);
	import sll_pkg::*;

	sll_cmd_t cmd;
	sll_sts_t sts;

	// decode and sequencing
	sll_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_beat  (char_beat),
		.sts        (sts),
		.cmd        (cmd)
	);

	// token storage and result register
	sll_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_beat  (tok_beat)
	);

endmodule

FILE: bench/stack_language_lexer_test.sv
// testbench for stack_language_lexer: a directed table, then random token streams
// depends on sll_pkg and the lexer rtl; self-checking against a built-in token predictor
module stack_language_lexer_test;
	import sll_pkg::*;

	// token codes for operators and keywords; NUMBER and STRING keywords share TT_NUMBER/TT_STRING
	localparam logic [4:0] TK_EOF = 5'd1, TK_NEWLINE = 5'd2, TK_VAR = 5'd4, TK_DUP = 5'd6;
	localparam logic [4:0] TK_POP = 5'd7, TK_SWP = 5'd8, TK_OVR = 5'd9, TK_ROT = 5'd10;
	localparam logic [4:0] TK_PLUS = 5'd11, TK_MINUS = 5'd12, TK_STAR = 5'd13;
	localparam logic [4:0] TK_SLASH = 5'd14, TK_PERCENT = 5'd15, TK_EQUAL = 5'd16;
	localparam logic [4:0] TK_BANG = 5'd17, TK_GREATER = 5'd18, TK_LESS = 5'd19;
	localparam logic [4:0] TK_AND = 5'd20, TK_ORR = 5'd21, TK_INV = 5'd22, TK_DGT = 5'd23;
	localparam logic [4:0] TK_LTR = 5'd24, TK_STK = 5'd25, TK_RTN = 5'd26;
	localparam logic [4:0] TK_COLON = 5'd27, TK_BYE = 5'd28;

	localparam int DIRECTED_ROWS = 24;
	localparam int RANDOM_BEATS  = 360;

	typedef enum logic [2:0] {
		LM_IDLE, LM_STRING, LM_WORD, LM_NUMBER, LM_STOPPED
	} lex_mode_e;

	// one row of the directed table: the beat, and a typed-in result where it is obvious
	typedef struct packed {
		lex_in_t  beat;
		logic     typed;
		lex_out_t want;
	} row_t;

	logic     clk;
	logic     arst_n;
	logic     char_valid;
	logic     char_ready;
	lex_in_t  char_beat;
	logic     tok_valid;
	logic     tok_ready;
	lex_out_t tok_beat;

	// predictor state
	lex_mode_e   mode;
	logic [7:0]  txt [MAX_TOKEN_CHARS];
	int unsigned txt_len;
	logic [31:0] acc;

	lex_out_t tokens_due [$];  // expected result beats, oldest first
	lex_out_t new_tokens [$];  // results caused by the latest accepted byte

	int beats_in;
	int fail_count;
	int send_calm;
	int recv_calm;

	stack_language_lexer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_beat  (char_beat),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_beat   (tok_beat)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic logic letter_byte(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic digit_byte(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// operator byte to token code, TT_NONE for anything else
	function automatic logic [4:0] op_of(input logic [7:0] c);
		case (c)
			"+":     return TK_PLUS;
			"-":     return TK_MINUS;
			"*":     return TK_STAR;
			"/":     return TK_SLASH;
			"%":     return TK_PERCENT;
			"=":     return TK_EQUAL;
			"!":     return TK_BANG;
			">":     return TK_GREATER;
			"<":     return TK_LESS;
			":":     return TK_COLON;
			default: return TT_NONE;
		endcase
	endfunction

	function automatic void push_res(input logic has, input logic [4:0] tt,
			input logic [7:0] ch, input logic [31:0] val, input err_code_t err,
			input logic lst);
		lex_out_t r;
		r.has_token    = has;
		r.token_type   = tt;
		r.text_char    = ch;
		r.number_value = val;
		r.error_code   = err;
		r.last         = lst;
		new_tokens.push_back(r);
	endfunction

	function automatic void clear_token();
		txt_len = 0;
		acc     = '0;
	endfunction

	// fatal errors silence the lexer until the end marker
	function automatic void stop_on(input err_code_t err);
		clear_token();
		mode = LM_STOPPED;
		push_res(1'b0, TT_NONE, 8'h00, 32'd0, err, 1'b1);
	endfunction

	function automatic logic add_char(input logic [7:0] c);
		if (txt_len >= MAX_TOKEN_CHARS)
			return 1'b0;
		txt[txt_len] = c;
		txt_len++;
		return 1'b1;
	endfunction

	// saturating decimal accumulate
	function automatic void add_digit(input logic [7:0] c);
		logic [35:0] v;
		v = 36'(acc) * 36'd10 + 36'(c - "0");
		if (v > 36'hFFFF_FFFF)
			v = 36'hFFFF_FFFF;
		acc = v[31:0];
	endfunction

	// keyword lookup on the uppercased word, right-justified into 7 bytes
	function automatic logic [4:0] word_code();
		logic [55:0] w;
		int unsigned j;
		w = '0;
		if (txt_len > 7)
			return TT_WORD;
		for (j = 0; j < txt_len; j++)
			w = {w[47:0], txt[j]};
		case (w)
			"EOF":     return TK_EOF;
			"NEWLINE": return TK_NEWLINE;
			"NUMBER":  return TT_NUMBER;
			"VAR":     return TK_VAR;
			"STRING":  return TT_STRING;
			"DUP":     return TK_DUP;
			"POP":     return TK_POP;
			"SWP":     return TK_SWP;
			"OVR":     return TK_OVR;
			"ROT":     return TK_ROT;
			"AND":     return TK_AND;
			"ORR":     return TK_ORR;
			"INV":     return TK_INV;
			"DGT":     return TK_DGT;
			"LTR":     return TK_LTR;
			"STK":     return TK_STK;
			"RTN":     return TK_RTN;
			"BYE":     return TK_BYE;
			default:   return TT_WORD;
		endcase
	endfunction

	// text run with last on the final char; an empty token is one beat without text
	function automatic void emit_text(input logic [4:0] tt, input logic [31:0] val);
		int unsigned j;
		if (txt_len == 0) begin
			push_res(1'b0, tt, 8'h00, val, ERR_NONE, 1'b1);
			return;
		end
		for (j = 0; j < txt_len; j++)
			push_res(1'b1, tt, txt[j], val, ERR_NONE, j + 1 == txt_len);
	endfunction

	function automatic void flush_token();
		if (mode == LM_WORD)
			emit_text(word_code(), 32'd0);
		else if (mode == LM_NUMBER)
			emit_text(TT_NUMBER, acc);
		clear_token();
		mode = LM_IDLE;
	endfunction

	function automatic void idle_byte(input logic [7:0] c);
		logic [4:0] t;
		t = op_of(c);
		if (c == CH_SPACE || c == CH_NL)
			return;
		if (t != TT_NONE) begin
			push_res(1'b1, t, c, 32'd0, ERR_NONE, 1'b1);
		end else if (c == CH_QUOTE) begin
			clear_token();
			mode = LM_STRING;
		end else if (letter_byte(c)) begin
			clear_token();
			mode = LM_WORD;
			void'(add_char(upcase(c)));
		end else if (digit_byte(c)) begin
			clear_token();
			mode = LM_NUMBER;
			void'(add_char(c));
			add_digit(c);
		end else begin
			push_res(1'b0, TT_NONE, 8'h00, 32'd0, ERR_UNKNOWN, 1'b1);
		end
	endfunction

	// one accepted input beat: fills new_tokens
	function automatic void lex_step(input lex_in_t b);
		logic [7:0] c;
		c = b.char_code;
		new_tokens.delete();
		if (b.is_end) begin
			if (mode == LM_STRING)
				push_res(1'b0, TT_NONE, 8'h00, 32'd0, ERR_UNTERM, 1'b1);
			else
				flush_token();
			clear_token();
			mode = LM_IDLE;
			return;
		end
		case (mode)
			LM_STRING: begin
				if (c == CH_QUOTE) begin
					emit_text(TT_STRING, 32'd0);
					clear_token();
					mode = LM_IDLE;
				end else if (c == CH_NL || c == CH_TAB || c == CH_CR || c == CH_BSLASH ||
						c == CH_PERCENT) begin
					stop_on(ERR_STR_CHAR);
				end else if (!add_char(c)) begin
					stop_on(ERR_TOO_LONG);
				end
			end
			LM_WORD: begin
				if (letter_byte(c) || digit_byte(c)) begin
					if (!add_char(upcase(c)))
						stop_on(ERR_TOO_LONG);
				end else begin
					// the terminating byte runs again in idle mode
					flush_token();
					idle_byte(c);
				end
			end
			LM_NUMBER: begin
				if (digit_byte(c)) begin
					if (!add_char(c))
						stop_on(ERR_TOO_LONG);
					else
						add_digit(c);
				end else if (c == CH_DOT) begin
					stop_on(ERR_FLOAT);
				end else begin
					flush_token();
					idle_byte(c);
				end
			end
			LM_IDLE: idle_byte(c);
			default: ;  // stopped: nothing until the end marker
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// per-beat wait, with occasional calm stretches of back-to-back beats
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic lex_out_t tok_res(input logic has, input logic [4:0] tt,
			input logic [7:0] ch, input err_code_t err);
		lex_out_t r;
		r.has_token    = has;
		r.token_type   = tt;
		r.text_char    = ch;
		r.number_value = 32'd0;
		r.error_code   = err;
		r.last         = 1'b1;
		return r;
	endfunction

	function automatic row_t row(input logic [7:0] c, input logic e, input logic typed,
			input lex_out_t want);
		row_t r;
		r.beat.char_code = c;
		r.beat.is_end    = e;
		r.typed          = typed;
		r.want           = want;
		return r;
	endfunction

	// mostly small tokens, now and then just under, right at or just over the size limit
	function automatic int pick_len(input int lo, input int hi);
		if ($urandom_range(0, 29) == 0)
			return $urandom_range(MAX_TOKEN_CHARS - 1, MAX_TOKEN_CHARS + 1);
		return $urandom_range(lo, hi);
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 9))
			0:       return "+";
			1:       return "-";
			2:       return "*";
			3:       return "/";
			4:       return "%";
			5:       return "=";
			6:       return "!";
			7:       return ">";
			8:       return "<";
			default: return ":";
		endcase
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'("A") + 8'($urandom_range(0, 25));
		if ($urandom_range(0, 1))
			c = c | 8'h20;
		return c;
	endfunction

	// any byte that a string may carry
	function automatic logic [7:0] rand_text_byte();
		logic [7:0] c;
		c = CH_QUOTE;
		while (c == CH_QUOTE || c == CH_BSLASH || c == CH_PERCENT || c == CH_NL ||
				c == CH_TAB || c == CH_CR) begin
			case ($urandom_range(0, 7))
				0:       c = 8'($urandom_range(0, 255));
				1, 2:    c = 8'($urandom_range(128, 255));
				default: c = 8'($urandom_range(32, 126));
			endcase
		end
		return c;
	endfunction

	// handshake one beat and run the predictor on it; the caller stores the results
	task automatic send_beat(input lex_in_t b);
		int gap;
		gap = draw_wait(send_calm);
		@(negedge clk);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_valid <= 1'b1;
		char_beat  <= b;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
		// bytes swallowed while stopped do not count as stimulus
		if (mode != LM_STOPPED || b.is_end)
			beats_in++;
		lex_step(b);
	endtask

	task automatic feed(input logic [7:0] c, input logic e);
		lex_in_t b;
		b.char_code = c;
		b.is_end    = e;
		send_beat(b);
		foreach (new_tokens[i])
			tokens_due.push_back(new_tokens[i]);
	endtask

	// sender holds off until the lexer has delivered everything owed
	task automatic drain();
		@(negedge clk);
		char_valid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
	endtask

	// one random token, or now and then none, followed by a random separator or by none
	task automatic send_token();
		int kind;
		int n;
		int j;
		string s;
		logic [7:0] c;
		kind = $urandom_range(0, 99);
		if (kind < 14) begin
			feed(rand_op(), 1'b0);
		end else if (kind < 26) begin
			// keyword in mixed case
			case ($urandom_range(0, 17))
				0: s = "EOF";    1: s = "NEWLINE"; 2: s = "NUMBER"; 3: s = "VAR";
				4: s = "STRING"; 5: s = "DUP";     6: s = "POP";    7: s = "SWP";
				8: s = "OVR";    9: s = "ROT";     10: s = "AND";   11: s = "ORR";
				12: s = "INV";   13: s = "DGT";    14: s = "LTR";   15: s = "STK";
				16: s = "RTN";   default: s = "BYE";
			endcase
			for (j = 0; j < s.len(); j++) begin
				c = s[j];
				if ($urandom_range(0, 1))
					c = c | 8'h20;
				feed(c, 1'b0);
			end
		end else if (kind < 44) begin
			n = pick_len(1, 9);
			feed(rand_letter(), 1'b0);
			for (j = 1; j < n; j++)
				feed($urandom_range(0, 3) == 0 ? 8'("0") + 8'($urandom_range(0, 9)) :
					rand_letter(), 1'b0);
		end else if (kind < 62) begin
			case ($urandom_range(0, 5))
				0: begin
					// right at and just past the saturation point
					s = $urandom_range(0, 1) ? "4294967295" : "4294967296";
					for (j = 0; j < s.len(); j++)
						feed(s[j], 1'b0);
				end
				1: begin
					n = $urandom_range(10, 14);
					repeat (n) feed("9", 1'b0);
				end
				default: begin
					n = pick_len(1, 8);
					repeat (n) feed(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
				end
			endcase
			if ($urandom_range(0, 9) == 0)
				feed(CH_DOT, 1'b0);
		end else if (kind < 78) begin
			feed(CH_QUOTE, 1'b0);
			n = pick_len(0, 8);
			for (j = 0; j < n; j++)
				feed(rand_text_byte(), 1'b0);
			case ($urandom_range(0, 19))
				0: feed(CH_NL, 1'b0);
				1: feed(CH_TAB, 1'b0);
				2: feed(CH_CR, 1'b0);
				3: feed(CH_BSLASH, 1'b0);
				4: feed(CH_PERCENT, 1'b0);
				5: feed(8'($urandom_range(0, 255)), 1'b1);  // string left open
				default: feed(CH_QUOTE, 1'b0);
			endcase
		end else if (kind < 88) begin
			feed(8'($urandom_range(0, 255)), 1'b0);
		end else if (kind < 93) begin
			feed(8'($urandom_range(0, 255)), 1'b1);
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: feed(CH_SPACE, 1'b0);
			6, 7:             feed(CH_NL, 1'b0);
			8:                feed(rand_op(), 1'b0);
			default:          ;  // run straight into the next token
		endcase
		// after a fatal error: a few ignored bytes, then the end marker
		if (mode == LM_STOPPED) begin
			repeat ($urandom_range(0, 3)) feed(8'($urandom_range(0, 255)), 1'b0);
			feed(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	// ---------------------------------------------------------------- sender and run control

	initial begin
		row_t plan [DIRECTED_ROWS];
		int i;
		int tok_count;
		clk        = 1'b0;
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_beat  = '0;
		mode       = LM_IDLE;
		txt_len    = 0;
		acc        = '0;
		beats_in   = 0;
		fail_count = 0;
		send_calm  = 0;
		tok_count  = 0;

		// directed table; typed expectations only where the answer is obvious
		plan[0]  = row("+", 1'b0, 1'b1, tok_res(1'b1, TK_PLUS, "+", ERR_NONE));
		plan[1]  = row(8'hff, 1'b0, 1'b1, tok_res(1'b0, TT_NONE, 8'h00, ERR_UNKNOWN));
		plan[2]  = row(8'h00, 1'b0, 1'b1, tok_res(1'b0, TT_NONE, 8'h00, ERR_UNKNOWN));
		plan[3]  = row(":", 1'b0, 1'b1, tok_res(1'b1, TK_COLON, ":", ERR_NONE));
		plan[4]  = row(CH_QUOTE, 1'b0, 1'b0, '0);
		// empty string
		plan[5]  = row(CH_QUOTE, 1'b0, 1'b1, tok_res(1'b0, TT_STRING, 8'h00, ERR_NONE));
		plan[6]  = row(CH_QUOTE, 1'b0, 1'b0, '0);
		plan[7]  = row("a", 1'b0, 1'b0, '0);
		// tab inside a string is fatal
		plan[8]  = row(CH_TAB, 1'b0, 1'b1, tok_res(1'b0, TT_NONE, 8'h00, ERR_STR_CHAR));
		plan[9]  = row("q", 1'b0, 1'b0, '0);
		plan[10] = row(8'h00, 1'b1, 1'b0, '0);
		plan[11] = row("7", 1'b0, 1'b0, '0);
		// dot after a digit run
		plan[12] = row(CH_DOT, 1'b0, 1'b1, tok_res(1'b0, TT_NONE, 8'h00, ERR_FLOAT));
		plan[13] = row(8'h00, 1'b1, 1'b0, '0);
		plan[14] = row("d", 1'b0, 1'b0, '0);
		plan[15] = row("u", 1'b0, 1'b0, '0);
		plan[16] = row("p", 1'b0, 1'b0, '0);
		// ends the keyword and is then an operator itself
		plan[17] = row(CH_PERCENT, 1'b0, 1'b0, '0);
		plan[18] = row(CH_QUOTE, 1'b0, 1'b0, '0);
		plan[19] = row("z", 1'b0, 1'b0, '0);
		plan[20] = row(8'h00, 1'b1, 1'b1, tok_res(1'b0, TT_NONE, 8'h00, ERR_UNTERM));
		plan[21] = row("4", 1'b0, 1'b0, '0);
		plan[22] = row(8'h00, 1'b1, 1'b0, '0);
		plan[23] = row(8'hff, 1'b1, 1'b0, '0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			send_beat(plan[i].beat);
			if (plan[i].typed)
				tokens_due.push_back(plan[i].want);
			else
				foreach (new_tokens[k])
					tokens_due.push_back(new_tokens[k]);
		end
		drain();

		// random token streams, pausing now and then until the output side catches up
		while (beats_in < DIRECTED_ROWS + RANDOM_BEATS) begin
			send_token();
			tok_count++;
			if (tok_count % 40 == 0)
				drain();
		end

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- receiver and checker

	initial begin
		lex_out_t got;
		lex_out_t exp_tok;
		int stall;
		tok_ready = 1'b0;
		recv_calm = 0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(recv_calm);
			@(negedge clk);
			if (stall > 0) begin
				tok_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			tok_ready <= 1'b1;
			@(posedge clk);
			while (tok_valid !== 1'b1) @(posedge clk);
			got = tok_beat;
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				fail_count++;
			end else begin
				exp_tok = tokens_due.pop_front();
				if (got.has_token !== exp_tok.has_token ||
						got.token_type !== exp_tok.token_type ||
						got.text_char !== exp_tok.text_char ||
						got.number_value !== exp_tok.number_value ||
						got.error_code !== exp_tok.error_code ||
						got.last !== exp_tok.last) begin
					$display("%0t: beat mismatch, expected has=%0d type=%0d char=%h val=%0d err=%0d last=%0d",
						$time, exp_tok.has_token, exp_tok.token_type, exp_tok.text_char,
						exp_tok.number_value, exp_tok.error_code, exp_tok.last);
					$display("%0t:                actual   has=%0d type=%0d char=%h val=%0d err=%0d last=%0d",
						$time, got.has_token, got.token_type, got.text_char,
						got.number_value, got.error_code, got.last);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/sll_pkg.sv
rtl/core/sll_dpath.sv
rtl/core/sll_ctrl.sv
rtl/core/stack_language_lexer.sv
bench/stack_language_lexer_test.sv
